@@ hw/rtl/byte_frequency_sort_unit_defines.svh @@
// ----------------------------------------------------------------------------
// byte frequency sort unit assertion macros
// shared helpers for the concurrent checks of the sort unit
// ----------------------------------------------------------------------------
`ifndef BYTE_FREQUENCY_SORT_UNIT_DEFINES_SVH
`define BYTE_FREQUENCY_SORT_UNIT_DEFINES_SVH

// same-cycle implication
`define BFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bfs check failed");

// next-cycle implication
`define BFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bfs check failed");

`endif

@@ hw/rtl/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// constants and types shared by the byte frequency sort unit
// ----------------------------------------------------------------------------
package bfs_pkg;

	localparam int MAX_LEN  = 65536;
	localparam int ALPHABET = 256;
	localparam int BINS     = 256;
	localparam int BIN_W    = $clog2(BINS);
	localparam int CNT_W    = $clog2(MAX_LEN + 1);
	localparam int KEY_W    = CNT_W + 8;

	typedef logic [7:0]       byte_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [KEY_W-1:0] key_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LDWR = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

@@ hw/rtl/bfs_req_if.sv @@
// ----------------------------------------------------------------------------
// bfs_req_if
// request channel: load or fetch command with its data byte
// ----------------------------------------------------------------------------
interface bfs_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

@@ hw/rtl/bfs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bfs_rsp_if
// response channel: one sorted byte with its flags
// ----------------------------------------------------------------------------
interface bfs_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic       truncated;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		output truncated, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_last,
		input truncated, output ready);
endinterface

@@ hw/rtl/bfs_ram.sv @@
// ----------------------------------------------------------------------------
// bfs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hw/rtl/byte_frequency_sort_unit.sv @@
// ----------------------------------------------------------------------------
// byte_frequency_sort_unit
// counts the bytes of a string, then gives it back sorted by byte frequency
// ----------------------------------------------------------------------------
// usage
// - req carries cmd and data_byte; a load (cmd 0) counts one byte, a fetch
//   (cmd 1) asks for the next byte of the sorted string
// - rsp carries one result per fetch: out_byte, out_valid, out_last and
//   truncated; loads give no result
// - a load reads the histogram bin, then writes it back
// - a fetch that stays on the current byte value answers without a scan
// - a fetch that moves to the next byte value walks all 256 bins of the
//   histogram ram to find the next largest count; the first fetch of a
//   string walks once more first
// - a fetch with nothing loaded answers straight from idle with out_valid low
// - once the result marked out_last is formed the histogram and counters
//   clear at once through per-bin valid flags, no clearing pass
// - reset clears all flags and counters, the unit is ready straight away
// - a stalled rsp holds its result in the output register; req is taken
//   again as soon as that result is being transferred
// ----------------------------------------------------------------------------
module byte_frequency_sort_unit (
	input logic    clk,
	input logic    arst_n,
	bfs_req_if.sink   req,
	bfs_rsp_if.source rsp
);
	import bfs_pkg::*;

	state_t st_q;

	// histogram ram and per-bin valid flags
	logic             ram_we;
	logic [BIN_W-1:0] ram_waddr;
	cnt_t             ram_wdata;
	logic             ram_re;
	logic [BIN_W-1:0] ram_raddr;
	cnt_t             ram_rdata;
	logic [BINS-1:0]  bin_vld_q;

	// string state
	cnt_t  total_q;
	logic  emitting_q;
	logic  overflow_q;
	byte_t cur_val_q;
	cnt_t  cur_cnt_q;
	cnt_t  rep_q;
	byte_t pend_q;
	byte_t ld_byte_q;

	// scan state
	logic [BIN_W:0]   scan_idx_q;
	logic             scan_first_q;
	logic             chk_vld_s1;
	logic [BIN_W-1:0] chk_val_s1;
	logic             chk_bin_s1;
	logic             found_q;
	key_t             best_q;

	// result register
	logic  res_vld_q;
	byte_t res_byte_q;
	logic  res_ok_q;
	logic  res_last_q;
	logic  res_trunc_q;

	logic  accept;
	logic  in_range;
	cnt_t  cand_cnt;
	key_t  cand_key;
	key_t  prev_key;
	logic  cand_take;
	logic  scan_done;

	assign req.ready = (st_q == ST_IDLE) && (!res_vld_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign in_range  = {1'b0, req.data_byte} < 9'(ALPHABET);

	assign rsp.valid     = res_vld_q;
	assign rsp.out_byte  = res_byte_q;
	assign rsp.out_valid = res_ok_q;
	assign rsp.out_last  = res_last_q;
	assign rsp.truncated = res_trunc_q;

	// candidate compare: key is count, then inverted value, so ties go low
	assign cand_cnt  = chk_bin_s1 ? ram_rdata : '0;
	assign cand_key  = {cand_cnt, ~chk_val_s1};
	assign prev_key  = {cur_cnt_q, ~cur_val_q};
	assign cand_take = chk_vld_s1 && (cand_cnt != '0) && (scan_first_q || cand_key < prev_key)
		&& (!found_q || cand_key > best_q);
	assign scan_done = scan_idx_q[BIN_W] && !chk_vld_s1;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = req.data_byte[BIN_W-1:0];
		if (st_q == ST_SCAN) begin
			ram_re    = !scan_idx_q[BIN_W];
			ram_raddr = scan_idx_q[BIN_W-1:0];
		end else if (accept && req.cmd == CMD_LOAD) begin
			ram_re = 1'b1;
		end
	end

	assign ram_we    = (st_q == ST_LDWR);
	assign ram_waddr = ld_byte_q[BIN_W-1:0];
	assign ram_wdata = (bin_vld_q[ld_byte_q[BIN_W-1:0]] ? ram_rdata : '0) + cnt_t'(1);

	bfs_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// scan pipeline payload
	always_ff @(posedge clk) begin
		chk_val_s1 <= scan_idx_q[BIN_W-1:0];
		chk_bin_s1 <= bin_vld_q[scan_idx_q[BIN_W-1:0]];
		if (cand_take) begin
			best_q <= cand_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			bin_vld_q    <= '0;
			total_q      <= '0;
			emitting_q   <= 1'b0;
			overflow_q   <= 1'b0;
			cur_val_q    <= '0;
			cur_cnt_q    <= '0;
			rep_q        <= '0;
			pend_q       <= '0;
			ld_byte_q    <= '0;
			scan_idx_q   <= '0;
			scan_first_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			res_vld_q    <= 1'b0;
			res_byte_q   <= '0;
			res_ok_q     <= 1'b0;
			res_last_q   <= 1'b0;
			res_trunc_q  <= 1'b0;
		end else begin
			if (rsp.ready) begin
				res_vld_q <= 1'b0;
			end
			chk_vld_s1 <= (st_q == ST_SCAN) && !scan_idx_q[BIN_W];
			case (st_q)
				ST_IDLE: begin
					if (accept && req.cmd == CMD_LOAD) begin
						if (!emitting_q && in_range) begin
							if (total_q >= cnt_t'(MAX_LEN)) begin
								overflow_q <= 1'b1;
							end else begin
								ld_byte_q <= req.data_byte;
								st_q      <= ST_LDWR;
							end
						end
					end else if (accept) begin
						if (emitting_q) begin
							st_q <= ST_EMIT;
						end else if (total_q == '0) begin
							// nothing loaded: empty result
							res_vld_q   <= 1'b1;
							res_byte_q  <= '0;
							res_ok_q    <= 1'b0;
							res_last_q  <= 1'b0;
							res_trunc_q <= overflow_q;
						end else begin
							scan_idx_q   <= '0;
							scan_first_q <= 1'b1;
							found_q      <= 1'b0;
							st_q         <= ST_SCAN;
						end
					end
				end
				ST_LDWR: begin
					bin_vld_q[ld_byte_q[BIN_W-1:0]] <= 1'b1;
					total_q <= total_q + cnt_t'(1);
					st_q    <= ST_IDLE;
				end
				ST_SCAN: begin
					if (!scan_idx_q[BIN_W]) begin
						scan_idx_q <= scan_idx_q + (BIN_W+1)'(1);
					end
					if (cand_take) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						cur_val_q <= ~best_q[7:0];
						cur_cnt_q <= best_q[KEY_W-1:8];
						rep_q     <= best_q[KEY_W-1:8];
						if (scan_first_q) begin
							emitting_q <= 1'b1;
							st_q       <= ST_EMIT;
						end else begin
							res_vld_q   <= 1'b1;
							res_byte_q  <= pend_q;
							res_ok_q    <= 1'b1;
							res_last_q  <= !found_q;
							res_trunc_q <= overflow_q;
							st_q        <= ST_IDLE;
							if (!found_q) begin
								// string done: clear for the next one
								bin_vld_q  <= '0;
								total_q    <= '0;
								emitting_q <= 1'b0;
								overflow_q <= 1'b0;
								cur_cnt_q  <= '0;
								rep_q      <= '0;
							end
						end
					end
				end
				ST_EMIT: begin
					if (rep_q > cnt_t'(1)) begin
						rep_q       <= rep_q - cnt_t'(1);
						res_vld_q   <= 1'b1;
						res_byte_q  <= cur_val_q;
						res_ok_q    <= 1'b1;
						res_last_q  <= 1'b0;
						res_trunc_q <= overflow_q;
						st_q        <= ST_IDLE;
					end else begin
						// last copy of this value: look for the next one
						pend_q       <= cur_val_q;
						scan_idx_q   <= '0;
						scan_first_q <= 1'b0;
						found_q      <= 1'b0;
						st_q         <= ST_SCAN;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

@@ hw/rtl/bfs_checker.sv @@
// ----------------------------------------------------------------------------
// bfs_checker
// port-level checks of the byte frequency sort unit
// ----------------------------------------------------------------------------
`include "byte_frequency_sort_unit_defines.svh"

module bfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       out_last
);
	`BFS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte))
	`BFS_ASSERT_NOW(a_empty_zero, clk, arst_n, rsp_valid && !out_valid, out_byte == 8'd0)
	`BFS_ASSERT_NOW(a_last_valid, clk, arst_n, rsp_valid && out_last, out_valid)
endmodule

bind byte_frequency_sort_unit bfs_checker u_bfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_byte  (rsp.out_byte),
	.out_valid (rsp.out_valid),
	.out_last  (rsp.out_last)
);
